// ----- sv/mpe_pkg.sv -----
// package for the multiclass perceptron engine: types, codes and defaults
// used by every module of the block but mpe_ram; depends on nothing

package mpe_pkg;

	localparam int NUM_CLASSES_DEF         = 16;
	localparam int NUM_FEATURES_DEF        = 1024;
	localparam int MAX_SAMPLE_FEATURES_DEF = 64;
	localparam int WEIGHT_BITS_DEF         = 16;

	localparam int FID_W   = 10;
	localparam int CLS_W   = 4;
	localparam int SCORE_W = 22;
	localparam int KIND_W  = 2;
	localparam int NACT_W  = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = 2;

	localparam logic [NACT_W-1:0] CLASSES_RESET = 5'd16;
	localparam logic [NACT_W-1:0] CLASSES_CAP   = 5'd16;

	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_TRAIN    = 1'b1;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 22'sh1FFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = -22'sh200000;

	typedef enum logic [KIND_W-1:0] {
		KIND_SCORE   = 2'd0,
		KIND_SAME    = 2'd1,
		KIND_UPDATED = 2'd2,
		KIND_REJECT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_ARG,
		ST_EMIT,
		ST_TRAIN,
		ST_UBUF,
		ST_UROW,
		ST_UWR
	} back_state_t;

	typedef struct packed {
		logic             op;
		logic [FID_W-1:0] fid;
		logic [CLS_W-1:0] target;
		logic             last;
		logic             feat_ok;
	} item_t;

	typedef struct packed {
		logic              avail;
		item_t             item;
		logic [NACT_W-1:0] n_act;
	} front_to_back_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_to_front_t;

endpackage

// ----- sv/mpe_ram.sv -----
// generic single write port ram with registered read
// no dependencies

module mpe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/mpe_front.sv -----
// front end: configuration register, item accept and classification, item queue
// depends on mpe_pkg

module mpe_front #(
	parameter int NUM_CLASSES  = mpe_pkg::NUM_CLASSES_DEF,
	parameter int NUM_FEATURES = mpe_pkg::NUM_FEATURES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [mpe_pkg::FID_W-1:0]      feature_id,
	input  logic [mpe_pkg::CLS_W-1:0]      label_class,
	input  logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mpe_pkg::NACT_W-1:0]     cfg_data,
	input  mpe_pkg::back_to_front_t        b2f,
	output mpe_pkg::front_to_back_t        f2b
);

	mpe_pkg::item_t                  fifo_q [mpe_pkg::FIFO_DEPTH];
	logic [mpe_pkg::FIFO_PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mpe_pkg::FIFO_PW:0]       fill_q;
	logic [mpe_pkg::NACT_W-1:0]      classes_q;
	logic [mpe_pkg::NACT_W-1:0]      n_act;
	logic                            push, full;
	mpe_pkg::item_t                  in_item;

	assign cfg_ready = 1'b1;
	assign full      = (fill_q == (mpe_pkg::FIFO_PW+1)'(mpe_pkg::FIFO_DEPTH));
	assign busy      = full | b2f.clearing;
	assign push      = start & ~busy;

	always_comb begin
		in_item.op      = op;
		in_item.fid     = feature_id;
		in_item.target  = label_class;
		in_item.last    = last;
		in_item.feat_ok = (32'(feature_id) < NUM_FEATURES);
	end

	// zero acts as one; the cap is the smaller of class count and sixteen
	always_comb begin
		n_act = classes_q;
		if (n_act == '0) begin
			n_act = mpe_pkg::NACT_W'(1);
		end
		if (32'(n_act) > NUM_CLASSES) begin
			n_act = mpe_pkg::NACT_W'(NUM_CLASSES);
		end
		if (n_act > mpe_pkg::CLASSES_CAP) begin
			n_act = mpe_pkg::CLASSES_CAP;
		end
	end

	always_comb begin
		f2b.avail = (fill_q != '0);
		f2b.item  = fifo_q[rd_ptr_q];
		f2b.n_act = n_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			classes_q <= mpe_pkg::CLASSES_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				classes_q <= cfg_data;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mpe_pkg::FIFO_PW'(1);
			end
			if (b2f.pop) begin
				rd_ptr_q <= rd_ptr_q + mpe_pkg::FIFO_PW'(1);
			end
			if (push && !b2f.pop) begin
				fill_q <= fill_q + (mpe_pkg::FIFO_PW+1)'(1);
			end else if (!push && b2f.pop) begin
				fill_q <= fill_q - (mpe_pkg::FIFO_PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ----- sv/mpe_back.sv -----
// back end: weight row accumulation, argmax, result emission and weight update
// depends on mpe_pkg and mpe_ram

module mpe_back #(
	parameter int NUM_CLASSES         = mpe_pkg::NUM_CLASSES_DEF,
	parameter int NUM_FEATURES        = mpe_pkg::NUM_FEATURES_DEF,
	parameter int MAX_SAMPLE_FEATURES = mpe_pkg::MAX_SAMPLE_FEATURES_DEF,
	parameter int WEIGHT_BITS         = mpe_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mpe_pkg::front_to_back_t              f2b,
	output mpe_pkg::back_to_front_t              b2f,
	output logic                                 res_valid,
	output logic [mpe_pkg::KIND_W-1:0]           kind,
	output logic [mpe_pkg::CLS_W-1:0]            class_index,
	output logic signed [mpe_pkg::SCORE_W-1:0]   score,
	output logic [mpe_pkg::CLS_W-1:0]            predicted_class,
	output logic                                 final_res
);

	localparam int AW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int BW    = (MAX_SAMPLE_FEATURES > 1) ? $clog2(MAX_SAMPLE_FEATURES) : 1;
	localparam int CNTW  = $clog2(MAX_SAMPLE_FEATURES + 1);
	localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int ROW_W = NUM_CLASSES * WEIGHT_BITS;
	localparam int SUM_W = 34;
	localparam int NW    = mpe_pkg::NACT_W;

	localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	mpe_pkg::back_state_t state_q, state_d;

	logic signed [mpe_pkg::SCORE_W-1:0] score_q [NUM_CLASSES];
	logic [AW-1:0]        clr_addr_q;
	logic [NW-1:0]        cls_q;
	logic [mpe_pkg::CLS_W-1:0] pred_q, tgt_q;
	logic                 op_q, ovf_q;
	logic [CNTW-1:0]      cnt_q, upd_q;
	logic [AW-1:0]        f_q;
	logic                 v_s1, feat_s1, last_s1, op_s1;
	logic [mpe_pkg::CLS_W-1:0] tgt_s1;

	logic                 pop, w_we, b_we, end_sample, better, reject, upd_last;
	logic                 emit_v, emit_fin;
	logic [mpe_pkg::KIND_W-1:0] emit_kind;
	logic [mpe_pkg::CLS_W-1:0]  emit_cls;
	logic signed [mpe_pkg::SCORE_W-1:0] emit_score, tgt_score, cls_score, pred_score;
	logic [AW-1:0]        w_waddr, w_raddr;
	logic [ROW_W-1:0]     w_wdata, w_rdata, new_row;
	logic [mpe_pkg::FID_W-1:0] b_rdata;

	mpe_ram #(.WIDTH(ROW_W), .DEPTH(NUM_FEATURES)) u_weights (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	mpe_ram #(.WIDTH(mpe_pkg::FID_W), .DEPTH(MAX_SAMPLE_FEATURES)) u_fbuf (
		.clk   (clk),
		.we    (b_we),
		.waddr (BW'(cnt_q)),
		.wdata (f2b.item.fid),
		.raddr (BW'(upd_q)),
		.rdata (b_rdata)
	);

	assign cls_score  = score_q[CW'(cls_q)];
	assign pred_score = score_q[CW'(pred_q)];
	assign tgt_score  = (32'(tgt_q) < NUM_CLASSES) ? score_q[CW'(tgt_q)] : '0;
	assign better     = (cls_score > pred_score);
	assign reject     = (NW'(tgt_q) >= f2b.n_act) | ovf_q;
	assign upd_last   = ((upd_q + CNTW'(1)) == cnt_q);

	// bump target up and predicted class down, each saturating
	always_comb begin
		logic signed [WEIGHT_BITS-1:0] w;
		new_row = w_rdata;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			w = w_rdata[c*WEIGHT_BITS +: WEIGHT_BITS];
			if (c == 32'(tgt_q)) begin
				new_row[c*WEIGHT_BITS +: WEIGHT_BITS] =
					(w == W_MAX) ? w : w + WEIGHT_BITS'(1);
			end else if (c == 32'(pred_q)) begin
				new_row[c*WEIGHT_BITS +: WEIGHT_BITS] =
					(w == W_MIN) ? w : w - WEIGHT_BITS'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpe_pkg::ST_CLEAR: begin
				if (clr_addr_q == AW'(NUM_FEATURES - 1)) begin
					state_d = mpe_pkg::ST_RUN;
				end
			end
			mpe_pkg::ST_RUN: begin
				if (v_s1 && last_s1) begin
					state_d = mpe_pkg::ST_ARG;
				end
			end
			mpe_pkg::ST_ARG: begin
				if (cls_q >= f2b.n_act) begin
					state_d = (op_q == mpe_pkg::OP_CLASSIFY) ? mpe_pkg::ST_EMIT
					                                         : mpe_pkg::ST_TRAIN;
				end
			end
			mpe_pkg::ST_EMIT: begin
				if ((cls_q + NW'(1)) == f2b.n_act) begin
					state_d = mpe_pkg::ST_RUN;
				end
			end
			mpe_pkg::ST_TRAIN: begin
				if (!reject && tgt_q != pred_q && cnt_q != '0) begin
					state_d = mpe_pkg::ST_UBUF;
				end else begin
					state_d = mpe_pkg::ST_RUN;
				end
			end
			mpe_pkg::ST_UBUF: state_d = mpe_pkg::ST_UROW;
			mpe_pkg::ST_UROW: state_d = mpe_pkg::ST_UWR;
			mpe_pkg::ST_UWR: begin
				state_d = upd_last ? mpe_pkg::ST_RUN : mpe_pkg::ST_UBUF;
			end
			default: state_d = mpe_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop        = 1'b0;
		w_we       = 1'b0;
		w_waddr    = clr_addr_q;
		w_wdata    = '0;
		w_raddr    = AW'(f2b.item.fid);
		end_sample = 1'b0;
		emit_v     = 1'b0;
		emit_kind  = mpe_pkg::KIND_SCORE;
		emit_cls   = tgt_q;
		emit_score = tgt_score;
		emit_fin   = 1'b1;
		unique case (state_q)
			mpe_pkg::ST_CLEAR: begin
				w_we = 1'b1;
			end
			mpe_pkg::ST_RUN: begin
				pop = f2b.avail & ~(v_s1 & last_s1);
			end
			mpe_pkg::ST_EMIT: begin
				emit_v     = 1'b1;
				emit_cls   = mpe_pkg::CLS_W'(cls_q);
				emit_score = cls_score;
				emit_fin   = ((cls_q + NW'(1)) == f2b.n_act);
				end_sample = emit_fin;
			end
			mpe_pkg::ST_TRAIN: begin
				emit_v = 1'b1;
				if (reject) begin
					emit_kind = mpe_pkg::KIND_REJECT;
				end else if (tgt_q == pred_q) begin
					emit_kind = mpe_pkg::KIND_SAME;
				end else begin
					emit_kind = mpe_pkg::KIND_UPDATED;
				end
				end_sample = (state_d == mpe_pkg::ST_RUN);
			end
			mpe_pkg::ST_UROW: begin
				w_raddr = AW'(b_rdata);
			end
			mpe_pkg::ST_UWR: begin
				w_we       = 1'b1;
				w_waddr    = f_q;
				w_wdata    = new_row;
				w_raddr    = f_q;
				end_sample = upd_last;
			end
			default: begin
			end
		endcase
	end

	assign b_we         = pop & f2b.item.feat_ok & (cnt_q < CNTW'(MAX_SAMPLE_FEATURES));
	assign b2f.pop      = pop;
	assign b2f.clearing = (state_q == mpe_pkg::ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mpe_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			res_valid  <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				score_q[c] <= '0;
			end
		end else begin
			state_q   <= state_d;
			v_s1      <= pop;
			res_valid <= emit_v;
			if (state_q == mpe_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (pop && f2b.item.feat_ok) begin
				if (cnt_q < CNTW'(MAX_SAMPLE_FEATURES)) begin
					cnt_q <= cnt_q + CNTW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			// the weight row read at a pop lands here in the cycle after it
			if (v_s1 && feat_s1) begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					logic signed [SUM_W-1:0] s;
					s = SUM_W'(score_q[c]) +
					    SUM_W'($signed(w_rdata[c*WEIGHT_BITS +: WEIGHT_BITS]));
					if (s > SUM_W'(mpe_pkg::SCORE_MAX)) begin
						score_q[c] <= mpe_pkg::SCORE_MAX;
					end else if (s < SUM_W'(mpe_pkg::SCORE_MIN)) begin
						score_q[c] <= mpe_pkg::SCORE_MIN;
					end else begin
						score_q[c] <= mpe_pkg::SCORE_W'(s);
					end
				end
			end
			if (end_sample) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				for (int c = 0; c < NUM_CLASSES; c++) begin
					score_q[c] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			feat_s1 <= f2b.item.feat_ok;
			last_s1 <= f2b.item.last;
			op_s1   <= f2b.item.op;
			tgt_s1  <= f2b.item.target;
		end
		if (state_q == mpe_pkg::ST_RUN && v_s1 && last_s1) begin
			op_q   <= op_s1;
			tgt_q  <= tgt_s1;
			cls_q  <= NW'(1);
			pred_q <= '0;
		end
		if (state_q == mpe_pkg::ST_ARG) begin
			if (cls_q >= f2b.n_act) begin
				cls_q <= '0;
			end else begin
				if (better) begin
					pred_q <= mpe_pkg::CLS_W'(cls_q);
				end
				cls_q <= cls_q + NW'(1);
			end
		end
		if (state_q == mpe_pkg::ST_EMIT) begin
			cls_q <= cls_q + NW'(1);
		end
		if (state_q == mpe_pkg::ST_TRAIN) begin
			upd_q <= '0;
		end
		if (state_q == mpe_pkg::ST_UROW) begin
			f_q <= AW'(b_rdata);
		end
		if (state_q == mpe_pkg::ST_UWR) begin
			upd_q <= upd_q + CNTW'(1);
		end
		if (emit_v) begin
			kind            <= emit_kind;
			class_index     <= emit_cls;
			score           <= emit_score;
			predicted_class <= pred_q;
			final_res       <= emit_fin;
		end
	end

endmodule

// ----- sv/multiclass_perceptron_engine_core.sv -----
// top level of the multiclass perceptron engine: front end, queue and back end
// depends on mpe_pkg, mpe_front, mpe_back and mpe_ram
//
//  channel   handshake          payload
//  input     start / busy       op, feature_id, label_class, last
//  config    cfg_valid/ready    cfg_data (classes in use)
//  result    res_valid strobe   kind, class_index, score, predicted_class, final_res
//
// an item that is not last can be popped while the weight row of the one before is
// still being added into all class scores; a queue of four words in front absorbs
// end of sample work. last item: its row is added in and the argmax runs over the n
// classes in use, then come n score words for classify, or for training one result
// word and, on an update, read buffer, read row and write row for each buffered feature
// after reset the weight memory is cleared, one row a cycle through all NUM_FEATURES
// rows, with busy high; results are strobed once and cannot be held off

module multiclass_perceptron_engine_core #(
	parameter int NUM_CLASSES         = mpe_pkg::NUM_CLASSES_DEF,
	parameter int NUM_FEATURES        = mpe_pkg::NUM_FEATURES_DEF,
	parameter int MAX_SAMPLE_FEATURES = mpe_pkg::MAX_SAMPLE_FEATURES_DEF,
	parameter int WEIGHT_BITS         = mpe_pkg::WEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               op,
	input  logic [mpe_pkg::FID_W-1:0]          feature_id,
	input  logic [mpe_pkg::CLS_W-1:0]          label_class,
	input  logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpe_pkg::NACT_W-1:0]         cfg_data,
	output logic                               res_valid,
	output logic [mpe_pkg::KIND_W-1:0]         kind,
	output logic [mpe_pkg::CLS_W-1:0]          class_index,
	output logic signed [mpe_pkg::SCORE_W-1:0] score,
	output logic [mpe_pkg::CLS_W-1:0]          predicted_class,
	output logic                               final_res
);

	mpe_pkg::front_to_back_t f2b;
	mpe_pkg::back_to_front_t b2f;

	mpe_front #(
		.NUM_CLASSES  (NUM_CLASSES),
		.NUM_FEATURES (NUM_FEATURES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.feature_id   (feature_id),
		.label_class  (label_class),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.b2f          (b2f),
		.f2b          (f2b)
	);

	mpe_back #(
		.NUM_CLASSES         (NUM_CLASSES),
		.NUM_FEATURES        (NUM_FEATURES),
		.MAX_SAMPLE_FEATURES (MAX_SAMPLE_FEATURES),
		.WEIGHT_BITS         (WEIGHT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.f2b             (f2b),
		.b2f             (b2f),
		.res_valid       (res_valid),
		.kind            (kind),
		.class_index     (class_index),
		.score           (score),
		.predicted_class (predicted_class),
		.final_res       (final_res)
	);

endmodule

// ----- sv/mpe_checker.sv -----
// port level checks for the multiclass perceptron engine, bound to the top level
// depends on mpe_pkg

module mpe_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               busy,
	input logic                               res_valid,
	input logic [mpe_pkg::KIND_W-1:0]         kind,
	input logic [mpe_pkg::CLS_W-1:0]          class_index,
	input logic signed [mpe_pkg::SCORE_W-1:0] score,
	input logic [mpe_pkg::CLS_W-1:0]          predicted_class,
	input logic                               final_res
);

	// training results come alone
	a_train_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != mpe_pkg::KIND_SCORE |-> final_res)
		else $error("training result not marked final");

	// class scores stream out in consecutive cycles, class by class
	a_scores_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !final_res |=> res_valid && kind == mpe_pkg::KIND_SCORE &&
		class_index == mpe_pkg::CLS_W'($past(class_index) + mpe_pkg::CLS_W'(1)) &&
		predicted_class == $past(predicted_class))
		else $error("score run broken");

	// a finished run is followed by a gap
	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && final_res |=> !res_valid)
		else $error("result right after final word");

	// a strobed word carries defined fields
	a_word_known: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !$isunknown({kind, class_index, score, predicted_class, final_res}))
		else $error("result word has unknown bits");

	a_busy_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(busy))
		else $error("busy unknown");

endmodule

bind multiclass_perceptron_engine_core mpe_checker u_mpe_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.busy            (busy),
	.res_valid       (res_valid),
	.kind            (kind),
	.class_index     (class_index),
	.score           (score),
	.predicted_class (predicted_class),
	.final_res       (final_res)
);
